// ===== rtl/lzot_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzot_pkg: shared definitions for the layered z-order table
// Field widths, action and status codes, and the structs that run between
// the control logic and the row of table cells.
// ----------------------------------------------------------------------------
package lzot_pkg;

  // Default sizing of the table
  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned ID_WIDTH_DEF    = 16;

  // Fixed field widths of the channels
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned SID_W   = 16;
  localparam int unsigned LAY_W   = 3;
  localparam int unsigned ST_W    = 3;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  // Layers run from wallpaper up to topmost
  localparam int unsigned          NUM_LAYERS = 5;
  localparam logic [LAY_W-1:0]     LAYER_TOP  = 3'd4;

  typedef enum logic [ACT_W-1:0] {
    ACT_ASSIGN = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_DONE      = 3'd0,
    ST_MOVED     = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NO_CAP    = 3'd3,
    ST_FULL      = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  // Update command broadcast to every cell when an item is taken
  typedef struct packed {
    logic             exec;
    logic             insert;
    logic             move;
    logic             remove;
    logic [LAY_W-1:0] layer;
  } cell_cmd_t;

  // Layers that the summary pass compares against
  typedef struct packed {
    logic [LAY_W-1:0] lay_sel;
    logic [LAY_W-1:0] lay_in;
    logic [LAY_W-1:0] lay_max;
    logic [LAY_W-1:0] lay_min;
  } cell_qry_t;

  // Per-cell flags seen by the control logic
  typedef struct packed {
    logic occ;
    logic match;
    logic pos_hit;
    logic cnt_hit;
    logic is_top;
    logic is_bot;
  } cell_flags_t;

  // Clamp layer codes above topmost to topmost
  function automatic logic [LAY_W-1:0] sat_layer(input logic [LAY_W-1:0] lay);
    return (lay > LAYER_TOP) ? LAYER_TOP : lay;
  endfunction

endpackage

// ===== rtl/lzot_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzot_if: item channels of the layered z-order table
// Request channel (action, surface id, layer) and result channel, both with
// a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lzot_in_if;
  import lzot_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [SID_W-1:0] surface_id;
  logic [LAY_W-1:0] layer;

  modport source (output valid, action, surface_id, layer, input ready);
  modport sink   (input valid, action, surface_id, layer, output ready);
endinterface

interface lzot_out_if;
  import lzot_pkg::*;

  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [CNT_W-1:0] position;
  logic [LAY_W-1:0] current_layer;
  logic [CNT_W-1:0] layer_count;
  logic [CNT_W-1:0] entry_count;
  logic [SID_W-1:0] top_id;
  logic [SID_W-1:0] bottom_id;

  modport source (output valid, status, position, current_layer, layer_count,
                  entry_count, top_id, bottom_id, input ready);
  modport sink   (input valid, status, position, current_layer, layer_count,
                  entry_count, top_id, bottom_id, output ready);
endinterface

// ===== rtl/lzot_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzot_cell: one slot of the z-order table
// Holds one id and its layer, matches the request id, takes its upper
// neighbor's entry when a remove closes the gap, and passes the ordering
// chains (position, top, bottom) on to its neighbors.
// ----------------------------------------------------------------------------
module lzot_cell #(
  parameter int unsigned ID_WIDTH = 16,
  parameter int unsigned CW       = 5,
  parameter int unsigned INDEX    = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [CW-1:0]            used_i,
  input  logic [ID_WIDTH-1:0]      key_i,
  input  lzot_pkg::cell_cmd_t      cmd_i,
  input  lzot_pkg::cell_qry_t      qry_i,
  input  logic [ID_WIDTH-1:0]      nbr_id_i,
  input  logic [lzot_pkg::LAY_W-1:0] nbr_layer_i,
  input  logic                     shift_i,
  output logic                     shift_o,
  input  logic                     before_i,
  output logic                     before_o,
  input  logic                     top_seen_i,
  output logic                     top_seen_o,
  input  logic                     bot_seen_i,
  output logic                     bot_seen_o,
  output logic [ID_WIDTH-1:0]      id_o,
  output logic [lzot_pkg::LAY_W-1:0] layer_o,
  output lzot_pkg::cell_flags_t    flags_o
);
  import lzot_pkg::*;

  localparam logic [CW-1:0] IDX = CW'(INDEX);

  logic [ID_WIDTH-1:0] id_q, id_d;
  logic [LAY_W-1:0]    layer_q, layer_d;
  logic                hit_q, hit_d;
  logic                occ, tail, match, mine_top, mine_bot;

  // Slot occupancy and id match
  assign occ   = IDX < used_i;
  assign tail  = IDX == used_i;
  assign match = occ && (id_q == key_i);

  // Next entry: append at the tail, relayer on a hit, shift down on remove
  always_comb begin
    id_d    = id_q;
    layer_d = layer_q;
    if (cmd_i.insert && tail) begin
      id_d    = key_i;
      layer_d = cmd_i.layer;
    end else if (cmd_i.move && match) begin
      layer_d = cmd_i.layer;
    end else if (cmd_i.remove && (shift_i || match)) begin
      id_d    = nbr_id_i;
      layer_d = nbr_layer_i;
    end
  end

  // Where the request id sits after the update
  always_comb begin
    if (cmd_i.insert) begin
      hit_d = tail;
    end else if (cmd_i.remove) begin
      hit_d = 1'b0;
    end else begin
      hit_d = match;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      id_q    <= id_d;
      layer_q <= layer_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.exec) begin
      hit_q <= hit_d;
    end
  end

  // Ordering chains of the summary pass
  assign mine_top   = occ && (layer_q == qry_i.lay_max);
  assign mine_bot   = occ && (layer_q == qry_i.lay_min);
  assign shift_o    = shift_i || match;
  assign before_o   = before_i || hit_q;
  assign top_seen_o = top_seen_i || mine_top;
  assign bot_seen_o = bot_seen_i || mine_bot;

  assign id_o    = id_q;
  assign layer_o = layer_q;

  // Count a same-layer entry only while the hit still lies above this slot
  always_comb begin
    flags_o.occ     = occ;
    flags_o.match   = match;
    flags_o.pos_hit = occ && ((layer_q < qry_i.lay_sel) ||
                              ((layer_q == qry_i.lay_sel) && !before_o));
    flags_o.cnt_hit = occ && (layer_q == qry_i.lay_in);
    flags_o.is_top  = mine_top && !top_seen_i;
    flags_o.is_bot  = mine_bot && !bot_seen_i;
  end

endmodule

// ===== rtl/layered_z_order_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// layered_z_order_table: layered stacking-order table of surface ids
// Keeps ids in insertion order with a layer each; assigns, removes and
// queries ids and reports position, layer, counts and top/bottom ids.
// ----------------------------------------------------------------------------
// Usage
//   in_i  : request items (action, surface_id, layer), valid/ready.
//   out_o : one result item per request, valid/ready, from an output register.
//   APB   : capability_enabled at byte address 0 (bit 0); pready is always 1.
// Timing
//   A request is taken in the idle cycle; the cell row matches the id and
//   applies the update at that edge. The following cycle runs the summary
//   pass down the cell row (position, layer count, top and bottom chains)
//   and loads the output register. A new request is taken only after the
//   summary of the last one has loaded the output register.
// Reset
//   The table is empty and capability_enabled is 1. Cell contents are not
//   cleared; only slots below the entry count are ever looked at.
// Stall
//   While the output register holds an untaken result, a new request is
//   still taken and applied; its summary then waits until the register
//   frees, and no further request is taken in the meantime.
// ----------------------------------------------------------------------------
module layered_z_order_table #(
  parameter int unsigned MAX_ENTRIES = lzot_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned ID_WIDTH    = lzot_pkg::ID_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lzot_in_if.sink                     in_i,
  lzot_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lzot_pkg::APB_AW-1:0] paddr,
  input  logic [lzot_pkg::APB_DW-1:0] pwdata,
  output logic [lzot_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import lzot_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ENTRIES);

  typedef enum logic {S_IDLE, S_SUM} state_e;

  state_e              state_q;
  logic                cap_q;
  logic [CW-1:0]       used_q, used_d;
  status_e             status_q, status_d;
  logic [LAY_W-1:0]    lay_in_q, lay_sel_q, lay_sel_d;
  logic                found_q, found_d;

  logic                accept;
  action_e             act;
  logic [ID_WIDTH-1:0] key;
  logic                id_zero, full, found;
  logic [LAY_W-1:0]    lay_sat, match_lay, lay_max, lay_min;
  logic                do_insert, do_move, do_remove;
  cell_cmd_t           cmd;
  cell_qry_t           qry;

  logic [ID_WIDTH-1:0] cell_id    [MAX_ENTRIES];
  logic [LAY_W-1:0]    cell_layer [MAX_ENTRIES];
  cell_flags_t         flags      [MAX_ENTRIES];
  logic [MAX_ENTRIES:0] shift_c, before_c, top_c, bot_c;

  logic [NUM_LAYERS-1:0] present;
  logic [CW-1:0]       pos_cnt, lay_cnt;
  logic [ID_WIDTH-1:0] top_id, bot_id;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = APB_DW'(cap_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 1'b1;
    end else if (psel && penable && pwrite && !paddr[APB_AW-1]) begin
      cap_q <= pwdata[0];
    end
  end

  // Request decode
  assign accept  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign act     = action_e'(in_i.action);
  assign key     = ID_WIDTH'(in_i.surface_id);
  assign id_zero = (key == '0);
  assign lay_sat = sat_layer(in_i.layer);
  assign full    = (used_q >= MAX_CNT);

  // Match result gathered from the cells
  always_comb begin
    found     = 1'b0;
    match_lay = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      found     = found | flags[i].match;
      match_lay = match_lay | (flags[i].match ? cell_layer[i] : '0);
    end
  end

  // Pick the action and its status
  always_comb begin
    do_insert = 1'b0;
    do_move   = 1'b0;
    do_remove = 1'b0;
    status_d  = ST_DONE;
    unique case (act)
      ACT_ASSIGN: begin
        priority if (id_zero) begin
          status_d = ST_EMPTY;
        end else if (!cap_q) begin
          status_d = ST_NO_CAP;
        end else if (found) begin
          status_d = ST_MOVED;
          do_move  = 1'b1;
        end else if (full) begin
          status_d = ST_FULL;
        end else begin
          do_insert = 1'b1;
        end
      end
      ACT_REMOVE: begin
        priority if (!cap_q) begin
          status_d = ST_NO_CAP;
        end else if (id_zero) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          do_remove = 1'b1;
        end
      end
      default: begin
        priority if (id_zero) begin
          status_d = ST_EMPTY;
        end else if (!found) begin
          status_d = ST_NOT_FOUND;
        end else begin
          status_d = ST_DONE;
        end
      end
    endcase
  end

  // State of the queried id after the update
  always_comb begin
    found_d   = do_insert || do_move || (found && !do_remove);
    lay_sel_d = (do_insert || do_move) ? lay_sat : match_lay;
    used_d    = used_q;
    if (do_insert) begin
      used_d = used_q + CW'(1);
    end else if (do_remove) begin
      used_d = used_q - CW'(1);
    end
  end

  always_comb begin
    cmd.exec   = accept;
    cmd.insert = accept && do_insert;
    cmd.move   = accept && do_move;
    cmd.remove = accept && do_remove;
    cmd.layer  = lay_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q    <= '0;
      status_q  <= ST_DONE;
      lay_in_q  <= '0;
      lay_sel_q <= '0;
      found_q   <= 1'b0;
    end else if (accept) begin
      used_q    <= used_d;
      status_q  <= status_d;
      lay_in_q  <= lay_sat;
      lay_sel_q <= lay_sel_d;
      found_q   <= found_d;
    end
  end

  // Row of cells
  assign shift_c[0]            = 1'b0;
  assign before_c[0]           = 1'b0;
  assign bot_c[0]              = 1'b0;
  assign top_c[MAX_ENTRIES]    = 1'b0;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic [ID_WIDTH-1:0] nbr_id;
    logic [LAY_W-1:0]    nbr_layer;

    if (g == MAX_ENTRIES - 1) begin : g_last
      assign nbr_id    = cell_id[g];
      assign nbr_layer = cell_layer[g];
    end else begin : g_mid
      assign nbr_id    = cell_id[g+1];
      assign nbr_layer = cell_layer[g+1];
    end

    lzot_cell #(
      .ID_WIDTH (ID_WIDTH),
      .CW       (CW),
      .INDEX    (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .used_i      (used_q),
      .key_i       (key),
      .cmd_i       (cmd),
      .qry_i       (qry),
      .nbr_id_i    (nbr_id),
      .nbr_layer_i (nbr_layer),
      .shift_i     (shift_c[g]),
      .shift_o     (shift_c[g+1]),
      .before_i    (before_c[g]),
      .before_o    (before_c[g+1]),
      .top_seen_i  (top_c[g+1]),
      .top_seen_o  (top_c[g]),
      .bot_seen_i  (bot_c[g]),
      .bot_seen_o  (bot_c[g+1]),
      .id_o        (cell_id[g]),
      .layer_o     (cell_layer[g]),
      .flags_o     (flags[g])
    );
  end

  // Layers present after the update, for the top and bottom chains
  always_comb begin
    present = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      for (int l = 0; l < NUM_LAYERS; l++) begin
        present[l] = present[l] | (flags[i].occ && (cell_layer[i] == LAY_W'(l)));
      end
    end
  end

  always_comb begin
    lay_max = '0;
    lay_min = '0;
    for (int l = 0; l < NUM_LAYERS; l++) begin
      if (present[l]) begin
        lay_max = LAY_W'(l);
      end
    end
    for (int l = NUM_LAYERS - 1; l >= 0; l--) begin
      if (present[l]) begin
        lay_min = LAY_W'(l);
      end
    end
  end

  always_comb begin
    qry.lay_sel = lay_sel_q;
    qry.lay_in  = lay_in_q;
    qry.lay_max = lay_max;
    qry.lay_min = lay_min;
  end

  // Summary: counts and top/bottom ids over the cell row
  always_comb begin
    pos_cnt = '0;
    lay_cnt = '0;
    top_id  = '0;
    bot_id  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      pos_cnt = pos_cnt + CW'(flags[i].pos_hit);
      lay_cnt = lay_cnt + CW'(flags[i].cnt_hit);
      top_id  = top_id | (flags[i].is_top ? cell_id[i] : '0);
      bot_id  = bot_id | (flags[i].is_bot ? cell_id[i] : '0);
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= S_IDLE;
      out_o.valid         <= 1'b0;
      out_o.status        <= '0;
      out_o.position      <= '0;
      out_o.current_layer <= '0;
      out_o.layer_count   <= '0;
      out_o.entry_count   <= '0;
      out_o.top_id        <= '0;
      out_o.bottom_id     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (out_o.valid && out_o.ready) begin
            out_o.valid <= 1'b0;
          end
          if (accept) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          if (!out_o.valid || out_o.ready) begin
            out_o.valid         <= 1'b1;
            out_o.status        <= status_q;
            out_o.position      <= CNT_W'(found_q ? pos_cnt : MAX_CNT);
            out_o.current_layer <= found_q ? lay_sel_q : '0;
            out_o.layer_count   <= CNT_W'(lay_cnt);
            out_o.entry_count   <= CNT_W'(used_q);
            out_o.top_id        <= SID_W'(top_id);
            out_o.bottom_id     <= SID_W'(bot_id);
            state_q             <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/lzot_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzot_checker: port-level checks for the layered z-order table
// Watches the result channel and the configuration port; bound to the top.
// ----------------------------------------------------------------------------
module lzot_checker #(
  parameter int unsigned MAX_ENTRIES = lzot_pkg::MAX_ENTRIES_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        pready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [lzot_pkg::ST_W-1:0]   status_i,
  input logic [lzot_pkg::CNT_W-1:0]  position_i,
  input logic [lzot_pkg::LAY_W-1:0]  current_layer_i,
  input logic [lzot_pkg::CNT_W-1:0]  layer_count_i,
  input logic [lzot_pkg::CNT_W-1:0]  entry_count_i,
  input logic [lzot_pkg::SID_W-1:0]  top_id_i,
  input logic [lzot_pkg::SID_W-1:0]  bottom_id_i
);
  import lzot_pkg::*;

  localparam logic [CNT_W-1:0] ABSENT_POS = CNT_W'(MAX_ENTRIES);
  localparam logic             NARROW     = (MAX_ENTRIES < 32);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
      $stable(position_i) && $stable(top_id_i) && $stable(bottom_id_i))
    else $error("result changed while stalled");

  // Keep the configuration port always ready
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready dropped");

  // Report an absent id at the end position with layer zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_NOT_FOUND || status_i == ST_EMPTY) |->
      current_layer_i == '0 && position_i == ABSENT_POS)
    else $error("absent id reported with a position or layer");

  // Show no top or bottom id for an empty table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    NARROW && out_valid_i && entry_count_i == '0 |->
      top_id_i == '0 && bottom_id_i == '0)
    else $error("empty table reports a top or bottom id");

  // Place a moved id inside the table and in a non-empty layer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    NARROW && out_valid_i && status_i == ST_MOVED |->
      position_i < entry_count_i && layer_count_i != '0)
    else $error("moved id not placed in its layer");

endmodule

bind layered_z_order_table lzot_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_lzot_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .pready_i        (pready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .status_i        (out_o.status),
  .position_i      (out_o.position),
  .current_layer_i (out_o.current_layer),
  .layer_count_i   (out_o.layer_count),
  .entry_count_i   (out_o.entry_count),
  .top_id_i        (out_o.top_id),
  .bottom_id_i     (out_o.bottom_id)
);
